### rtl/lws_pkg.sv
`timescale 1ns / 1ps

package lws_pkg;

  // Defaults for the top-level parameters
  localparam int FRAC_BITS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 48;

  // Fixed field widths of the sample and result words
  localparam int TIME_W = 48;
  localparam int LAT_W  = 32;
  localparam int MEAN_W = 48;
  localparam int VAR_W  = 62;
  localparam int CNT_W  = 32;

  // Squared-deviation accumulator and divider geometry (two quotient bits per cycle)
  localparam int ACC_W   = 64;
  localparam int VAR_CYC = ACC_W / 2;
  localparam int STEP_W  = $clog2(VAR_CYC + 1);

  // Sample word operation codes
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } lws_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       take;       // sample word accepted: latch latency, bump count
    logic       clear;      // clear word accepted: zero the statistics
    logic       mdiv_load;  // load divider with |x - mean| / n
    logic       div_step;   // one divider iteration
    logic       mean_upd;   // fold quotient into the mean
    logic       d1_calc;    // |x - new mean|, clear product accumulator
    logic       mul_step;   // accumulate one partial product
    logic [1:0] mul_idx;    // which partial product
    logic       acc_upd;    // add scaled product into squared-deviation sum
    logic       vdiv_load;  // load divider with sum / (n - 1)
    logic       var_zero;   // fewer than two samples: variance is zero
    logic       var_end;    // take variance from divider, saturated
    logic       out_load;   // copy results into the output register
  } lws_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_lt2;
  } lws_status_t;

endpackage

### rtl/lws_sample_if.sv
`timescale 1ns / 1ps

interface lws_sample_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic                      has_time;
  logic [lws_pkg::TIME_W-1:0] send_time;
  logic [lws_pkg::TIME_W-1:0] arrival_time;

  modport source (output valid, output op, output has_time, output send_time,
                  output arrival_time, input ready);
  modport sink (input valid, input op, input has_time, input send_time,
                input arrival_time, output ready);
endinterface

### rtl/lws_result_if.sv
`timescale 1ns / 1ps

interface lws_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [lws_pkg::LAT_W-1:0]  latency_us;
  logic signed [lws_pkg::MEAN_W-1:0] mean_q16;
  logic [lws_pkg::VAR_W-1:0]         variance;
  logic [lws_pkg::CNT_W-1:0]         sample_count;

  modport source (output valid, output latency_us, output mean_q16, output variance,
                  output sample_count, input ready);
  modport sink (input valid, input latency_us, input mean_q16, input variance,
                input sample_count, output ready);
endinterface

### rtl/lws_ctrl.sv
`timescale 1ns / 1ps

module lws_ctrl #(
  parameter int FRAC_BITS = lws_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic                 has_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lws_pkg::lws_status_t status,
  output lws_pkg::lws_cmd_t    cmd
);

  // Mean division: magnitude operand width, two bits per cycle
  localparam int AW       = 33 + FRAC_BITS;
  localparam int MEAN_CYC = (AW + 1) / 2;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MDIV, S_MEAN, S_D1, S_MUL, S_ACC,
    S_VPREP, S_VDIV, S_VEND, S_DONE
  } state_t;

  state_t                     state;
  logic [lws_pkg::STEP_W-1:0] step_cnt;
  logic [1:0]                 mul_idx;

  assign in_ready = (state == S_IDLE);

  // Command decode
  always_comb begin
    cmd           = '0;
    cmd.mul_idx   = mul_idx;
    case (state)
      S_IDLE: begin
        cmd.take  = in_valid && (op == lws_pkg::OP_SAMPLE) && has_time;
        cmd.clear = in_valid && (op == lws_pkg::OP_CLEAR);
      end
      S_PREP:  cmd.mdiv_load = 1'b1;
      S_MDIV:  cmd.div_step  = 1'b1;
      S_MEAN:  cmd.mean_upd  = 1'b1;
      S_D1:    cmd.d1_calc   = 1'b1;
      S_MUL:   cmd.mul_step  = 1'b1;
      S_ACC:   cmd.acc_upd   = 1'b1;
      S_VPREP: begin
        cmd.var_zero  = status.cnt_lt2;
        cmd.vdiv_load = !status.cnt_lt2;
      end
      S_VDIV:  cmd.div_step  = 1'b1;
      S_VEND:  cmd.var_end   = 1'b1;
      S_DONE:  cmd.out_load  = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

  // State, counters and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      mul_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      // result valid: set when a word is loaded, dropped when taken
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && (op == lws_pkg::OP_SAMPLE) && has_time) state <= S_PREP;
        end
        S_PREP: begin
          step_cnt <= lws_pkg::STEP_W'(MEAN_CYC);
          state    <= S_MDIV;
        end
        S_MDIV: begin
          step_cnt <= step_cnt - 1'b1;
          if (step_cnt == lws_pkg::STEP_W'(1)) state <= S_MEAN;
        end
        S_MEAN: state <= S_D1;
        S_D1: begin
          mul_idx <= '0;
          state   <= S_MUL;
        end
        S_MUL: begin
          mul_idx <= mul_idx + 1'b1;
          if (mul_idx == 2'd3) state <= S_ACC;
        end
        S_ACC: state <= S_VPREP;
        S_VPREP: begin
          step_cnt <= lws_pkg::STEP_W'(lws_pkg::VAR_CYC);
          state    <= status.cnt_lt2 ? S_DONE : S_VDIV;
        end
        S_VDIV: begin
          step_cnt <= step_cnt - 1'b1;
          if (step_cnt == lws_pkg::STEP_W'(1)) state <= S_VEND;
        end
        S_VEND: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/lws_datapath.sv
`timescale 1ns / 1ps

module lws_datapath #(
  parameter int FRAC_BITS  = lws_pkg::FRAC_BITS_DEF,
  parameter int TIME_WIDTH = lws_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lws_pkg::lws_cmd_t                 cmd,
  output lws_pkg::lws_status_t              status,
  input  logic [lws_pkg::TIME_W-1:0]        send_time,
  input  logic [lws_pkg::TIME_W-1:0]        arrival_time,
  output logic signed [lws_pkg::LAT_W-1:0]  latency_us,
  output logic signed [lws_pkg::MEAN_W-1:0] mean_q16,
  output logic [lws_pkg::VAR_W-1:0]         variance,
  output logic [lws_pkg::CNT_W-1:0]         sample_count
);

  localparam int TW         = lws_pkg::TIME_W;
  localparam int LW         = lws_pkg::LAT_W;
  localparam int CW         = lws_pkg::CNT_W;
  localparam int QW         = lws_pkg::ACC_W;
  localparam int XW         = LW + FRAC_BITS;     // scaled latency / mean
  localparam int AW         = XW + 1;             // magnitude of a difference
  localparam int PW         = 2 * AW;             // full product
  localparam int MEAN_CYC   = (AW + 1) / 2;
  localparam int MDIV_SHIFT = QW - 2 * MEAN_CYC;
  localparam int SQ_SHIFT   = 2 * FRAC_BITS;

  localparam logic [TW-1:0] T_MASK = TW'(((TW + 1)'(1) << TIME_WIDTH) - (TW + 1)'(1));
  localparam logic signed [TW:0] LAT_MAX = (TW + 1)'(31'h7FFFFFFF);
  localparam logic signed [TW:0] LAT_MIN = -(TW + 1)'(33'h080000000);

  // Statistics state
  logic [CW-1:0]         count;
  logic signed [XW-1:0]  mean;
  logic [QW-1:0]         sq_acc;
  logic [lws_pkg::VAR_W-1:0] var_r;

  // Working registers
  logic signed [LW-1:0]  lat_r;
  logic                  neg_r;
  logic [AW-1:0]         a1, a2;
  logic [QW-1:0]         dq;
  logic [CW-1:0]         dr, dd;
  logic [PW-1:0]         prod_acc;

  // Latency from the masked timestamps, saturated to 32 bits
  logic signed [TW:0] t_diff;
  logic signed [LW-1:0] lat_sat;
  always_comb begin
    t_diff = $signed({1'b0, arrival_time & T_MASK}) - $signed({1'b0, send_time & T_MASK});
    if (t_diff > LAT_MAX)      lat_sat = LW'(LAT_MAX);
    else if (t_diff < LAT_MIN) lat_sat = LW'(LAT_MIN);
    else                       lat_sat = LW'(t_diff);
  end

  // Scaled sample and its differences from the mean
  logic signed [XW-1:0] x;
  logic signed [XW:0]   diff_m;
  logic [AW-1:0]        mag_m;
  assign x      = XW'(lat_r) <<< FRAC_BITS;
  assign diff_m = (XW + 1)'(x) - (XW + 1)'(mean);
  assign mag_m  = diff_m[XW] ? AW'(-diff_m) : AW'(diff_m);

  // Divider: two restoring steps per cycle
  logic [CW:0]   r_a, r_b;
  logic [CW-1:0] r_a2, r_b2;
  logic          q_a, q_b;
  always_comb begin
    r_a = {dr, dq[QW-1]};
    q_a = (r_a >= {1'b0, dd});
    r_a2 = q_a ? CW'(r_a - {1'b0, dd}) : CW'(r_a);
    r_b = {r_a2, dq[QW-2]};
    q_b = (r_b >= {1'b0, dd});
    r_b2 = q_b ? CW'(r_b - {1'b0, dd}) : CW'(r_b);
  end

  // Mean update from the signed quotient
  logic signed [XW+1:0] q_s, mean_sum;
  always_comb begin
    q_s      = $signed({1'b0, dq[AW-1:0]});
    if (neg_r) q_s = -q_s;
    mean_sum = (XW + 2)'(mean) + q_s;
  end

  // One 32x32 partial product per cycle
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [1:0]  p_sum;
  always_comb begin
    pa    = cmd.mul_idx[0] ? 32'(a1[AW-1:32]) : a1[31:0];
    pb    = cmd.mul_idx[1] ? 32'(a2[AW-1:32]) : a2[31:0];
    pp    = pa * pb;
    p_sum = 2'(cmd.mul_idx[0]) + 2'(cmd.mul_idx[1]);
  end

  // Scaled product, saturated, then saturating accumulate
  logic [PW-1:0] p_shift;
  logic [QW-1:0] term;
  logic [QW:0]   sq_sum;
  always_comb begin
    p_shift = prod_acc >> SQ_SHIFT;
    term    = (|p_shift[PW-1:QW]) ? '1 : p_shift[QW-1:0];
    sq_sum  = {1'b0, sq_acc} + {1'b0, term};
  end

  assign status.cnt_lt2 = (count < CW'(2));

  // Statistics state, cleared on reset and on a clear word
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count  <= '0;
      mean   <= '0;
      sq_acc <= '0;
      var_r  <= '0;
    end else begin
      if (cmd.take && count != '1) count <= count + 1'b1;
      if (cmd.mean_upd) mean <= XW'(mean_sum);
      if (cmd.acc_upd) sq_acc <= sq_sum[QW] ? '1 : sq_sum[QW-1:0];
      if (cmd.var_zero) var_r <= '0;
      if (cmd.var_end)
        var_r <= (|dq[QW-1:lws_pkg::VAR_W]) ? '1 : dq[lws_pkg::VAR_W-1:0];
    end
  end

  // Working registers and output word
  always_ff @(posedge clk) begin
    if (cmd.take) lat_r <= lat_sat;
    if (cmd.mdiv_load) begin
      a2    <= mag_m;
      neg_r <= diff_m[XW];
      dq    <= QW'(mag_m) << MDIV_SHIFT;
      dr    <= '0;
      dd    <= count;
    end
    if (cmd.vdiv_load) begin
      dq <= sq_acc;
      dr <= '0;
      dd <= count - 1'b1;
    end
    if (cmd.div_step) begin
      dq <= {dq[QW-3:0], q_a, q_b};
      dr <= r_b2;
    end
    if (cmd.d1_calc) begin
      a1       <= mag_m;
      prod_acc <= '0;
    end
    if (cmd.mul_step) prod_acc <= prod_acc + (PW'(pp) << {p_sum, 5'd0});
    if (cmd.out_load) begin
      latency_us   <= lat_r;
      mean_q16     <= lws_pkg::MEAN_W'(mean);
      variance     <= var_r;
      sample_count <= count;
    end
  end

endmodule

### rtl/latency_welford_statistics.sv
`timescale 1ns / 1ps

// Latency statistics: each sample word gives arrival minus send time (low TIME_WIDTH bits
// of each timestamp), saturated to signed 32 bits, and folds it into a running mean
// (FRAC_BITS fraction bits) and sample variance by Welford's method; one result word per
// sample with latency, mean, variance (zero below two samples) and the saturating count.
// A clear word zeroes the statistics and a sample word without a timestamp is dropped,
// both with no result. The mean division by the count and the variance division run on
// one shared two-bits-per-cycle divider, and the 49x49 product takes four 32x32 partial
// products. The first sample after a clear skips the variance division. One sample is in
// work at a time; the next is accepted as soon as its result sits in the output register,
// even while that result still waits to be taken.
module latency_welford_statistics #(
  parameter int FRAC_BITS  = lws_pkg::FRAC_BITS_DEF,
  parameter int TIME_WIDTH = lws_pkg::TIME_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  lws_sample_if.sink   sample_in,
  lws_result_if.source result_out
);

  lws_pkg::lws_cmd_t    cmd;
  lws_pkg::lws_status_t status;

  // Sequencer
  lws_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_ready (sample_in.ready),
    .op       (sample_in.op),
    .has_time (sample_in.has_time),
    .out_valid(result_out.valid),
    .out_ready(result_out.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and statistics state
  lws_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .send_time   (sample_in.send_time),
    .arrival_time(sample_in.arrival_time),
    .latency_us  (result_out.latency_us),
    .mean_q16    (result_out.mean_q16),
    .variance    (result_out.variance),
    .sample_count(result_out.sample_count)
  );

endmodule

### rtl/lws_checker.sv
`timescale 1ns / 1ps

module lws_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_op,
  input logic                              in_has_time,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [lws_pkg::LAT_W-1:0]  out_latency,
  input logic signed [lws_pkg::MEAN_W-1:0] out_mean,
  input logic [lws_pkg::VAR_W-1:0]         out_variance,
  input logic [lws_pkg::CNT_W-1:0]         out_count
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_latency) && $stable(out_mean) &&
      $stable(out_variance) && $stable(out_count))
    else $error("result word changed while stalled");

  // A taken sample closes the input while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_op && in_has_time |=> !in_ready)
    else $error("input open right after a sample word");

  // Every result counts at least its own sample
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count != '0)
    else $error("result word with zero sample count");

  // Variance is zero below two samples
  a_var_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_count < lws_pkg::CNT_W'(2) |-> out_variance == '0)
    else $error("nonzero variance from a single sample");

endmodule

bind latency_welford_statistics lws_checker u_lws_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample_in.valid),
  .in_ready    (sample_in.ready),
  .in_op       (sample_in.op),
  .in_has_time (sample_in.has_time),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .out_latency (result_out.latency_us),
  .out_mean    (result_out.mean_q16),
  .out_variance(result_out.variance),
  .out_count   (result_out.sample_count)
);

### dv/tb_latency_welford_statistics.sv
`timescale 1ns / 1ps

module tb_latency_welford_statistics;

  localparam int FRAC   = lws_pkg::FRAC_BITS_DEF;
  localparam int TIME_W = lws_pkg::TIME_W;
  localparam int LAT_W  = lws_pkg::LAT_W;
  localparam int MEAN_W = lws_pkg::MEAN_W;
  localparam int VAR_W  = lws_pkg::VAR_W;
  localparam int CNT_W  = lws_pkg::CNT_W;
  localparam int ACC_W  = lws_pkg::ACC_W;
  localparam bit [TIME_W-1:0] TIME_MAX = '1;
  localparam bit [VAR_W-1:0] VAR_MAX = '1;
  localparam longint LAT_HI = 64'sd2147483647;
  localparam longint LAT_LO = -64'sd2147483648;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic signed [LAT_W-1:0]  latency;
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [CNT_W-1:0]         count;
  } stats_word_t;

  logic clk = 1'b0;
  logic rst;

  lws_sample_if sample_bus ();
  lws_result_if result_bus ();

  latency_welford_statistics i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_bus),
    .result_out(result_bus)
  );

  always #10 clk = ~clk;

  // running statistics as the block should hold them
  bit [CNT_W-1:0] stat_count;
  longint         stat_mean;
  bit [ACC_W-1:0] stat_sqdev;
  bit [VAR_W-1:0] stat_var;

  stats_word_t expected_stats[$];
  int mismatches = 0;
  int src_idle_pct = 7;
  int sink_idle_pct = 72;
  int hold_left = 0;

  function automatic bit [TIME_W-1:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // Welford update for one accepted word; queues the stats word it produces
  function automatic void predict_stats(lws_pkg::lws_op_t op, bit has_time,
                                        bit [TIME_W-1:0] send_us,
                                        bit [TIME_W-1:0] arrival_us);
    longint diff, lat, x, prev, n, d1, d2;
    bit [63:0] a, b, term, quot;
    bit [127:0] prod;
    bit [64:0] sum;
    stats_word_t w;
    if (op == lws_pkg::OP_CLEAR) begin
      stat_count = '0;
      stat_mean  = 0;
      stat_sqdev = '0;
      stat_var   = '0;
      return;
    end
    if (!has_time) return;

    diff = longint'(arrival_us) - longint'(send_us);
    lat = (diff > LAT_HI) ? LAT_HI : (diff < LAT_LO) ? LAT_LO : diff;
    x = lat * (64'sd1 << FRAC);
    if (stat_count != '1) stat_count++;
    n = longint'(stat_count);

    // mean step truncates toward zero
    prev = stat_mean;
    stat_mean = prev + (x - prev) / n;
    d1 = x - stat_mean;
    d2 = x - prev;
    a = (d1 < 0) ? -d1 : d1;
    b = (d2 < 0) ? -d2 : d2;
    prod = ({64'b0, a} * {64'b0, b}) >> (2 * FRAC);
    term = (|prod[127:64]) ? '1 : prod[63:0];
    sum = {1'b0, stat_sqdev} + {1'b0, term};
    stat_sqdev = sum[64] ? '1 : sum[63:0];

    // variance reads zero until there are two samples
    if (stat_count < 2) begin
      stat_var = '0;
    end else begin
      quot = stat_sqdev / (64'(stat_count) - 64'd1);
      stat_var = (quot > 64'(VAR_MAX)) ? VAR_MAX : quot[VAR_W-1:0];
    end

    w.latency  = lat[LAT_W-1:0];
    w.mean     = stat_mean[MEAN_W-1:0];
    w.variance = stat_var;
    w.count    = stat_count;
    expected_stats.push_back(w);
  endfunction

  function automatic void flag_mismatch(string field, bit [63:0] got, bit [63:0] want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
  endfunction

  // offer one sample word; starts and ends at a falling edge
  task automatic send_word(lws_pkg::lws_op_t op, bit has_time, bit [TIME_W-1:0] send_us,
                           bit [TIME_W-1:0] arrival_us);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_bus.valid = 1'b0;
      @(negedge clk);
    end
    sample_bus.valid        = 1'b1;
    sample_bus.op           = op;
    sample_bus.has_time     = has_time;
    sample_bus.send_time    = send_us;
    sample_bus.arrival_time = arrival_us;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    predict_stats(op, has_time, send_us, arrival_us);
    @(negedge clk);
  endtask

  task automatic wait_results();
    sample_bus.valid = 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random stalls plus an optional long hold-off
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_bus.ready = 1'b0;
        hold_left--;
      end else begin
        result_bus.ready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // compare every taken result word with the oldest prediction
  always @(posedge clk) begin : result_check
    stats_word_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing expected (latency %h)", $time,
                   result_bus.latency_us);
      end else begin
        want = expected_stats.pop_front();
        if (result_bus.latency_us !== want.latency)
          flag_mismatch("latency_us", 64'(result_bus.latency_us), 64'(want.latency));
        if (result_bus.mean_q16 !== want.mean)
          flag_mismatch("mean_q16", 64'(result_bus.mean_q16), 64'(want.mean));
        if (result_bus.variance !== want.variance)
          flag_mismatch("variance", 64'(result_bus.variance), 64'(want.variance));
        if (result_bus.sample_count !== want.count)
          flag_mismatch("sample_count", 64'(result_bus.sample_count), 64'(want.count));
      end
    end
  end

  // first samples after reset: zero, ordinary, largest in-range latencies
  task automatic test_first_samples();
    send_word(lws_pkg::OP_SAMPLE, 1'b1, 48'd1000, 48'd1000);
    send_word(lws_pkg::OP_SAMPLE, 1'b1, 48'd5, 48'd1005);
    send_word(lws_pkg::OP_SAMPLE, 1'b1, 48'd0, 48'd2147483647);
    send_word(lws_pkg::OP_SAMPLE, 1'b1, 48'd2147483648, 48'd0);
    wait_results();
  endtask

  // latencies beyond signed 32 bits clamp
  task automatic test_latency_saturation();
    send_word(lws_pkg::OP_SAMPLE, 1'b1, 48'd0, TIME_MAX);
    send_word(lws_pkg::OP_SAMPLE, 1'b1, TIME_MAX, 48'd0);
    send_word(lws_pkg::OP_SAMPLE, 1'b1, 48'd0, 48'd2147483648);
    send_word(lws_pkg::OP_SAMPLE, 1'b1, 48'd2147483649, 48'd0);
    wait_results();
  endtask

  // words without a timestamp vanish; clear restarts the count
  task automatic test_drop_and_clear();
    send_word(lws_pkg::OP_SAMPLE, 1'b0, TIME_MAX, TIME_MAX);
    send_word(lws_pkg::OP_SAMPLE, 1'b0, 48'd0, TIME_MAX);
    send_word(lws_pkg::OP_CLEAR, 1'b0, 48'd0, 48'd0);
    send_word(lws_pkg::OP_SAMPLE, 1'b1, 48'd100, 48'd350);
    send_word(lws_pkg::OP_SAMPLE, 1'b1, 48'd7, 48'd7);
    send_word(lws_pkg::OP_CLEAR, 1'b1, TIME_MAX, 48'd0);
    send_word(lws_pkg::OP_SAMPLE, 1'b1, TIME_MAX, TIME_MAX);
    wait_results();
  endtask

  // swinging between the clamp limits drives the deviation sum and variance to saturation
  task automatic test_deviation_saturation();
    send_word(lws_pkg::OP_CLEAR, 1'b1, 48'd0, 48'd0);
    repeat (3) begin
      send_word(lws_pkg::OP_SAMPLE, 1'b1, 48'd0, TIME_MAX);
      send_word(lws_pkg::OP_SAMPLE, 1'b1, TIME_MAX, 48'd0);
    end
    wait_results();
  endtask

  // result side blocks for a long stretch while samples keep coming
  task automatic test_output_backpressure();
    bit [TIME_W-1:0] t0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_left = 400;
    repeat (6) begin
      t0 = rand48();
      send_word(lws_pkg::OP_SAMPLE, 1'b1, t0, t0 + 48'($urandom_range(9000)));
    end
    wait_results();
  endtask

  // mostly realistic latencies in runs between clears, with drops and wild timestamps
  task automatic test_random_traffic(int words, int src_pct, int snk_pct);
    int taken;
    int pick;
    bit [TIME_W-1:0] t0, t1;
    longint lat;
    src_idle_pct  = src_pct;
    sink_idle_pct = snk_pct;
    taken = 0;
    while (taken < words) begin
      t0 = rand48();
      t1 = rand48();
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_word(lws_pkg::OP_CLEAR, 1'($urandom_range(1)), t0, t1);
        taken++;
      end else if (pick < 9) begin
        send_word(lws_pkg::OP_SAMPLE, 1'b0, t0, t1);
      end else if (pick < 17) begin
        send_word(lws_pkg::OP_SAMPLE, 1'b1, t0, t1);
        taken++;
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) lat = longint'($urandom_range(5000));
        else if (pick < 80) lat = longint'($urandom_range(4000)) - 2000;
        else lat = longint'($signed($urandom));
        send_word(lws_pkg::OP_SAMPLE, 1'b1, t0, t0 + 48'(lat));
        taken++;
      end
    end
    wait_results();
  endtask

  initial begin
    sample_bus.valid        = 1'b0;
    sample_bus.op           = 1'b0;
    sample_bus.has_time     = 1'b0;
    sample_bus.send_time    = '0;
    sample_bus.arrival_time = '0;
    stat_count = '0;
    stat_mean  = 0;
    stat_sqdev = '0;
    stat_var   = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_first_samples();
    test_latency_saturation();
    test_drop_and_clear();
    test_deviation_saturation();
    test_output_backpressure();
    test_random_traffic(150, 7, 72);
    test_random_traffic(150, 72, 7);
    test_random_traffic(150, 0, 0);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_stats.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
